>>> design/mic_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the magnetometer iron calibration block.
// No dependencies.
package mic_pkg;

    // root / divide unit widths
    localparam int SD_NW       = 56;  // operand shift register (radicand or aligned numerator)
    localparam int SD_DW       = 29;  // divisor
    localparam int SD_RW       = 31;  // partial remainder
    localparam int SD_QW       = 41;  // quotient / root
    localparam int SD_CW       = 6;   // step counter
    localparam int SD_RT_STEPS = 28;
    localparam int SD_DV_STEPS = 41;

    typedef struct packed {
        logic start;
        logic root;   // 1: square root, 0: divide
    } mic_sd_ctl_t;

endpackage

>>> design/magnetometer_iron_calibration_unit.sv
`timescale 1ns / 1ps
// Magnetometer hard/soft-iron correction with on-line calibration.
// Correct transaction goes through the shared 18x18 multiplier. The final trace item adds a
// pair scan (one RAM read per row and one per pair partner, two multiplies per pair) plus
// the bit-serial roots/divides. Not ready while an item is in work; output stalls hold off
// acceptance. Async active-low reset restores the default bias/matrix.
// Depends on mic_pkg, mic_ram, mic_sqdiv.
module magnetometer_iron_calibration_unit #(
    parameter int CAL_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mag_x[15:0], mag_y[31:16], button[32], zero pad
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // out_x, out_y, phase[33:32], point_taken, cal_done, pad
);
    import mic_pkg::*;

    localparam int AW = $clog2(CAL_SAMPLES);
    localparam int CW = $clog2(CAL_SAMPLES + 1);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RANGE = 2'd1;
    localparam logic [1:0] PH_TRACE = 2'd2;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_C0   = 5'd1;
    localparam logic [4:0] S_C1   = 5'd2;
    localparam logic [4:0] S_C2   = 5'd3;
    localparam logic [4:0] S_C3   = 5'd4;
    localparam logic [4:0] S_C4   = 5'd5;
    localparam logic [4:0] S_RNG  = 5'd6;
    localparam logic [4:0] S_T0   = 5'd7;
    localparam logic [4:0] S_T1   = 5'd8;
    localparam logic [4:0] S_T2   = 5'd9;
    localparam logic [4:0] S_T3   = 5'd10;
    localparam logic [4:0] S_T4   = 5'd11;
    localparam logic [4:0] S_FI   = 5'd12;
    localparam logic [4:0] S_FIW  = 5'd13;
    localparam logic [4:0] S_FJ   = 5'd14;
    localparam logic [4:0] S_FJW  = 5'd15;
    localparam logic [4:0] S_FP0  = 5'd16;
    localparam logic [4:0] S_FP1  = 5'd17;
    localparam logic [4:0] S_FP2  = 5'd18;
    localparam logic [4:0] S_RS   = 5'd19;
    localparam logic [4:0] S_RW   = 5'd20;
    localparam logic [4:0] S_DS   = 5'd21;
    localparam logic [4:0] S_DW   = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    localparam logic [15:0] MAG_CLAMP = 16'd40000;

    function automatic logic [15:0] rnd_sat(input logic signed [36:0] v);
        logic signed [36:0] t;
        begin
            t = (v + 37'sd4096) >>> 13;
            if (t > 37'sd32767)
                rnd_sat = 16'h7fff;
            else if (t < -37'sd32768)
                rnd_sat = 16'h8000;
            else
                rnd_sat = t[15:0];
        end
    endfunction

    logic [4:0]          state_reg;
    logic [1:0]          phase_reg;
    logic signed [15:0]  in_x_reg, in_y_reg;
    logic                in_btn_reg;
    logic signed [15:0]  xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [16:0]  bx_reg, by_reg;
    logic signed [15:0]  m_reg [4];
    logic [16:0]         rng_x_reg, rng_y_reg;
    logic [CW-1:0]       cnt_reg;
    logic [35:0]         min_reg;
    logic                min_vld_reg;
    logic signed [15:0]  last_x_reg, last_y_reg;
    logic signed [35:0]  prod_reg, acc_reg;
    logic                gx_reg;
    logic [15:0]         res_x_reg, res_y_reg;
    logic                res_taken_reg, res_done_reg;
    logic [AW-1:0]       i_reg, j_reg;
    logic signed [15:0]  pix_reg, piy_reg, pjx_reg, pjy_reg;
    logic [35:0]         best_reg;
    logic signed [15:0]  a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic                root_sel_reg;
    logic [27:0]         sa_reg, sb_reg;
    logic [1:0]          k_reg;
    logic                ovalid_reg;
    logic [15:0]         ox_reg, oy_reg;
    logic [1:0]          ophase_reg;
    logic                otaken_reg, odone_reg;

    logic signed [17:0]  mul_a, mul_b;
    logic signed [17:0]  x8, y8;
    logic signed [16:0]  dlx, dly, pdx, pdy;
    logic [15:0]         adx, ady;
    logic signed [36:0]  sum;
    logic                init_rng;
    logic signed [15:0]  lo_x, hi_x, lo_y, hi_y;
    logic                take;
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata;
    logic signed [17:0]  e1x, e1y, e2x, e2y;
    logic [16:0]         nx, ny, n_sel;
    logic                cw, neg;
    logic [27:0]         s_sel;
    logic [15:0]         mag;
    logic [15:0]         m_val;
    mic_sd_ctl_t         sd_ctl;
    logic [SD_NW-1:0]    sd_num;
    logic [SD_DW-1:0]    sd_den;
    logic                sd_done;
    logic [SD_QW-1:0]    sd_res;
    logic [40:0]         div_n;

    // datapath helpers
    always_comb
    begin
        x8  = {in_x_reg[15], in_x_reg, 1'b0} - {bx_reg[16], bx_reg};
        y8  = {in_y_reg[15], in_y_reg, 1'b0} - {by_reg[16], by_reg};
        dlx = {in_x_reg[15], in_x_reg} - {last_x_reg[15], last_x_reg};
        dly = {in_y_reg[15], in_y_reg} - {last_y_reg[15], last_y_reg};
        adx = dlx[16] ? 16'(-dlx) : dlx[15:0];
        ady = dly[16] ? 16'(-dly) : dly[15:0];
        pdx = {pix_reg[15], pix_reg} - {pjx_reg[15], pjx_reg};
        pdy = {piy_reg[15], piy_reg} - {pjy_reg[15], pjy_reg};
        sum = {acc_reg[35], acc_reg} + {prod_reg[35], prod_reg};

        init_rng = (phase_reg != PH_RANGE);
        lo_x = (init_rng || in_x_reg < xmin_reg) ? in_x_reg : xmin_reg;
        hi_x = (init_rng || in_x_reg > xmax_reg) ? in_x_reg : xmax_reg;
        lo_y = (init_rng || in_y_reg < ymin_reg) ? in_y_reg : ymin_reg;
        hi_y = (init_rng || in_y_reg > ymax_reg) ? in_y_reg : ymax_reg;

        // stepped on both axes: floor(range/N) < |d|  <=>  range < |d|*N
        take = (cnt_reg == '0) || (gx_reg && ($unsigned(prod_reg) > 36'(rng_y_reg)));

        e1x = {a1x_reg[15], a1x_reg, 1'b0} - {bx_reg[16], bx_reg};
        e1y = {a1y_reg[15], a1y_reg, 1'b0} - {by_reg[16], by_reg};
        e2x = {a2x_reg[15], a2x_reg, 1'b0} - {bx_reg[16], bx_reg};
        e2y = {a2y_reg[15], a2y_reg, 1'b0} - {by_reg[16], by_reg};
        nx  = e1x[17] ? 17'(-e1x) : e1x[16:0];
        ny  = e1y[17] ? 17'(-e1y) : e1y[16:0];
        cw  = (e1x > 18'sd0 && e1y > 18'sd0) || (e2x > 18'sd0 && e2y > 18'sd0);

        n_sel = (k_reg == 2'd0 || k_reg == 2'd3) ? nx : ny;
        s_sel = k_reg[1] ? sb_reg : sa_reg;
        neg   = (k_reg == 2'd1) ? !cw : ((k_reg == 2'd2) ? cw : 1'b0);
        div_n = {1'b0, n_sel, 23'b0} + 41'(s_sel);

        if (s_sel == '0)
            mag = (n_sel != '0) ? MAG_CLAMP : 16'd0;
        else if (sd_res > SD_QW'(MAG_CLAMP))
            mag = MAG_CLAMP;
        else
            mag = sd_res[15:0];
        if (neg)
            m_val = mag[15] ? 16'h8000 : 16'(-mag);
        else
            m_val = mag[15] ? 16'h7fff : mag;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_C0:
            begin
                mul_a = {{2{m_reg[0][15]}}, m_reg[0]};
                mul_b = x8;
            end
            S_C1:
            begin
                mul_a = {{2{m_reg[1][15]}}, m_reg[1]};
                mul_b = y8;
            end
            S_C2:
            begin
                mul_a = {{2{m_reg[2][15]}}, m_reg[2]};
                mul_b = x8;
            end
            S_C3:
            begin
                mul_a = {{2{m_reg[3][15]}}, m_reg[3]};
                mul_b = y8;
            end
            S_T0:
            begin
                mul_a = x8;
                mul_b = x8;
            end
            S_T1:
            begin
                mul_a = y8;
                mul_b = y8;
            end
            S_T2:
            begin
                mul_a = {2'b00, adx};
                mul_b = 18'(CAL_SAMPLES);
            end
            S_T3:
            begin
                mul_a = {2'b00, ady};
                mul_b = 18'(CAL_SAMPLES);
            end
            S_FP0:
            begin
                mul_a = {pdx[16], pdx};
                mul_b = {pdx[16], pdx};
            end
            S_FP1:
            begin
                mul_a = {pdy[16], pdy};
                mul_b = {pdy[16], pdy};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = (state_reg == S_T4) && take;
        ram_raddr = (state_reg == S_FI) ? i_reg : j_reg;
        sd_ctl.start = (state_reg == S_RS) || (state_reg == S_DS && s_sel != '0);
        sd_ctl.root  = (state_reg == S_RS);
        if (state_reg == S_RS)
            sd_num = {(root_sel_reg ? min_reg : best_reg), 20'b0};
        else
            sd_num = {div_n, 15'b0};
        sd_den = {s_sel, 1'b0};
    end

    mic_ram #(
        .WIDTH(32),
        .DEPTH(CAL_SAMPLES)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({in_y_reg, in_x_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mic_sqdiv u_sqdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (sd_ctl),
        .num_in (sd_num),
        .den_in (sd_den),
        .done   (sd_done),
        .res    (sd_res)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            in_btn_reg    <= 1'b0;
            xmin_reg      <= '0;
            xmax_reg      <= '0;
            ymin_reg      <= '0;
            ymax_reg      <= '0;
            bx_reg        <= 17'sd99;
            by_reg        <= -17'sd452;
            m_reg[0]      <= 16'sd3645;
            m_reg[1]      <= -16'sd2442;
            m_reg[2]      <= 16'sd3280;
            m_reg[3]      <= 16'sd4896;
            rng_x_reg     <= '0;
            rng_y_reg     <= '0;
            cnt_reg       <= '0;
            min_reg       <= '0;
            min_vld_reg   <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            acc_reg       <= '0;
            gx_reg        <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_taken_reg <= 1'b0;
            res_done_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pix_reg       <= '0;
            piy_reg       <= '0;
            pjx_reg       <= '0;
            pjy_reg       <= '0;
            best_reg      <= '0;
            a1x_reg       <= '0;
            a1y_reg       <= '0;
            a2x_reg       <= '0;
            a2y_reg       <= '0;
            root_sel_reg  <= 1'b0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            k_reg         <= '0;
            ovalid_reg    <= 1'b0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            ophase_reg    <= '0;
            otaken_reg    <= 1'b0;
            odone_reg     <= 1'b0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (ovalid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                ovalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        in_x_reg      <= s_axis_tdata[15:0];
                        in_y_reg      <= s_axis_tdata[31:16];
                        in_btn_reg    <= s_axis_tdata[32];
                        res_x_reg     <= '0;
                        res_y_reg     <= '0;
                        res_taken_reg <= 1'b0;
                        res_done_reg  <= 1'b0;
                        if (!s_axis_tuser)
                            state_reg <= S_C0;
                        else if (phase_reg == PH_TRACE)
                            state_reg <= S_T0;
                        else
                            state_reg <= S_RNG;
                    end
                end
                S_C0:
                begin
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    res_x_reg <= rnd_sat(sum);
                    state_reg <= S_C3;
                end
                S_C3:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_C4;
                end
                S_C4:
                begin
                    res_y_reg <= rnd_sat(sum);
                    state_reg <= S_OUT;
                end
                S_RNG:
                begin
                    xmin_reg <= lo_x;
                    xmax_reg <= hi_x;
                    ymin_reg <= lo_y;
                    ymax_reg <= hi_y;
                    if (in_btn_reg)
                    begin
                        bx_reg      <= {lo_x[15], lo_x} + {hi_x[15], hi_x};
                        by_reg      <= {lo_y[15], lo_y} + {hi_y[15], hi_y};
                        rng_x_reg   <= 17'({hi_x[15], hi_x} - {lo_x[15], lo_x});
                        rng_y_reg   <= 17'({hi_y[15], hi_y} - {lo_y[15], lo_y});
                        cnt_reg     <= '0;
                        min_reg     <= '0;
                        min_vld_reg <= 1'b0;
                        phase_reg   <= PH_TRACE;
                    end
                    else
                    begin
                        phase_reg <= PH_RANGE;
                    end
                    state_reg <= S_OUT;
                end
                S_T0:
                begin
                    state_reg <= S_T1;
                end
                S_T1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    if (!min_vld_reg || sum[35:0] < min_reg)
                    begin
                        min_reg     <= sum[35:0];
                        min_vld_reg <= 1'b1;
                    end
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    gx_reg    <= $unsigned(prod_reg) > 36'(rng_x_reg);
                    state_reg <= S_T4;
                end
                S_T4:
                begin
                    if (take)
                    begin
                        cnt_reg       <= cnt_reg + CW'(1);
                        last_x_reg    <= in_x_reg;
                        last_y_reg    <= in_y_reg;
                        res_taken_reg <= 1'b1;
                    end
                    if (take && cnt_reg == CW'(CAL_SAMPLES - 1))
                    begin
                        best_reg  <= '0;
                        i_reg     <= '0;
                        state_reg <= S_FI;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_FI:
                begin
                    state_reg <= S_FIW;
                end
                S_FIW:
                begin
                    pix_reg   <= ram_rdata[15:0];
                    piy_reg   <= ram_rdata[31:16];
                    j_reg     <= i_reg + AW'(1);
                    state_reg <= S_FJ;
                end
                S_FJ:
                begin
                    state_reg <= S_FJW;
                end
                S_FJW:
                begin
                    pjx_reg   <= ram_rdata[15:0];
                    pjy_reg   <= ram_rdata[31:16];
                    state_reg <= S_FP0;
                end
                S_FP0:
                begin
                    state_reg <= S_FP1;
                end
                S_FP1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_FP2;
                end
                S_FP2:
                begin
                    // first pair stands in when no pair beats zero
                    if (sum[35:0] > best_reg || (i_reg == '0 && j_reg == AW'(1)))
                    begin
                        a1x_reg <= pix_reg;
                        a1y_reg <= piy_reg;
                        a2x_reg <= pjx_reg;
                        a2y_reg <= pjy_reg;
                    end
                    if (sum[35:0] > best_reg)
                    begin
                        best_reg <= sum[35:0];
                    end
                    if (j_reg == AW'(CAL_SAMPLES - 1))
                    begin
                        if (i_reg == AW'(CAL_SAMPLES - 2))
                        begin
                            root_sel_reg <= 1'b0;
                            state_reg    <= S_RS;
                        end
                        else
                        begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= S_FI;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + AW'(1);
                        state_reg <= S_FJ;
                    end
                end
                S_RS:
                begin
                    state_reg <= S_RW;
                end
                S_RW:
                begin
                    if (sd_done)
                    begin
                        if (!root_sel_reg)
                        begin
                            sa_reg       <= sd_res[27:0];
                            root_sel_reg <= 1'b1;
                            state_reg    <= S_RS;
                        end
                        else
                        begin
                            sb_reg    <= sd_res[27:0];
                            k_reg     <= '0;
                            state_reg <= S_DS;
                        end
                    end
                end
                S_DS:
                begin
                    if (s_sel == '0)
                    begin
                        m_reg[k_reg] <= m_val;
                        if (k_reg == 2'd3)
                        begin
                            phase_reg    <= PH_IDLE;
                            res_done_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DW;
                    end
                end
                S_DW:
                begin
                    if (sd_done)
                    begin
                        m_reg[k_reg] <= m_val;
                        if (k_reg == 2'd3)
                        begin
                            phase_reg    <= PH_IDLE;
                            res_done_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_DS;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        ox_reg     <= res_x_reg;
                        oy_reg     <= res_y_reg;
                        ophase_reg <= phase_reg;
                        otaken_reg <= res_taken_reg;
                        odone_reg  <= res_done_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'b0000, odone_reg, otaken_reg, ophase_reg, oy_reg, ox_reg};

endmodule

>>> design/mic_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/mic_sqdiv.sv
`timescale 1ns / 1ps
// Bit-serial square root / restoring divider sharing one subtractor.
// Depends on mic_pkg.
module mic_sqdiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mic_pkg::mic_sd_ctl_t       ctl,
    input  logic [mic_pkg::SD_NW-1:0]  num_in,
    input  logic [mic_pkg::SD_DW-1:0]  den_in,
    output logic                       done,
    output logic [mic_pkg::SD_QW-1:0]  res
);
    import mic_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              root_reg;
    logic [SD_CW-1:0]  cnt_reg;
    logic [SD_RW-1:0]  rem_reg;
    logic [SD_NW-1:0]  num_reg;
    logic [SD_QW-1:0]  q_reg;
    logic [SD_DW-1:0]  den_reg;

    logic [SD_RW-1:0]  rem_sh;
    logic [SD_RW-1:0]  trial;
    logic [SD_RW:0]    diff;
    logic              ge;

    always_comb
    begin
        if (root_reg)
        begin
            rem_sh = {rem_reg[SD_RW-3:0], num_reg[SD_NW-1 -: 2]};
            trial  = {q_reg[SD_RW-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[SD_RW-2:0], num_reg[SD_NW-1]};
            trial  = {{(SD_RW-SD_DW){1'b0}}, den_reg};
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = !diff[SD_RW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            root_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                root_reg <= ctl.root;
                cnt_reg  <= ctl.root ? SD_CW'(SD_RT_STEPS) : SD_CW'(SD_DV_STEPS);
                rem_reg  <= '0;
                q_reg    <= '0;
                num_reg  <= num_in;
                den_reg  <= den_in;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[SD_RW-1:0] : rem_sh;
                q_reg   <= {q_reg[SD_QW-2:0], ge};
                num_reg <= root_reg ? {num_reg[SD_NW-3:0], 2'b00} : {num_reg[SD_NW-2:0], 1'b0};
                cnt_reg <= cnt_reg - SD_CW'(1);
                if (cnt_reg == SD_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = q_reg;

endmodule

>>> verif/mic_scoreboard.sv
`timescale 1ns / 1ps
// Checker for magnetometer_iron_calibration_unit: watches both stream channels,
// predicts each result from the accepted input and compares. Depends on nothing.
module mic_scoreboard #(
    parameter int CAL_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          errors,
    output int          pending
);

    localparam logic OP_CORRECT = 1'b0;
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RANGE = 2'd1;
    localparam logic [1:0] PH_TRACE = 2'd2;

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [1:0]         ph;
        logic               taken;
        logic               done;
    } mag_result_t;

    mag_result_t result_q[$];

    logic [1:0]  phase_r;
    int          lim[4];          // x min, x max, y min, y max
    longint      bias[2];
    longint      mat[4];
    longint      stp[2];
    int          pt_x[CAL_SAMPLES];
    int          pt_y[CAL_SAMPLES];
    int          npts;
    longint unsigned min_d;
    bit          min_ok;

    assign pending = result_q.size();

    function automatic longint unsigned adiff(longint a, longint b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // n / sqrt(d) in Q4.12, rounded, saturated
    function automatic longint q12_ratio(longint unsigned n, longint unsigned d, bit neg);
        longint unsigned s;
        longint unsigned mag;
        s = int_sqrt(d << 20);
        if (s == 0) mag = (n != 0) ? 40000 : 0;
        else mag = ((n << 23) + s) / (2 * s);
        if (mag > 40000) mag = 40000;
        return sat16(neg ? -longint'(mag) : longint'(mag));
    endfunction

    task automatic solve_matrix();
        int a1, a2;
        longint unsigned best, dd, nx, ny;
        bit cw;
        a1 = 0;
        a2 = 1;
        best = 0;
        for (int i = 0; i + 1 < CAL_SAMPLES; i++)
            for (int j = i + 1; j < CAL_SAMPLES; j++) begin
                dd = adiff(pt_x[i], pt_x[j]) ** 2 + adiff(pt_y[i], pt_y[j]) ** 2;
                if (dd > best) begin
                    best = dd;
                    a1 = i;
                    a2 = j;
                end
            end
        nx = adiff(2 * longint'(pt_x[a1]), bias[0]);
        ny = adiff(2 * longint'(pt_y[a1]), bias[1]);
        cw = (2 * longint'(pt_x[a1]) > bias[0] && 2 * longint'(pt_y[a1]) > bias[1]) ||
             (2 * longint'(pt_x[a2]) > bias[0] && 2 * longint'(pt_y[a2]) > bias[1]);
        mat[0] = q12_ratio(nx, best, 1'b0);
        mat[1] = q12_ratio(ny, best, !cw);
        mat[2] = q12_ratio(ny, min_d, cw);
        mat[3] = q12_ratio(nx, min_d, 1'b0);
    endtask

    task automatic predict_item(logic op, int x, int y, logic btn);
        mag_result_t r;
        longint x8, y8, vx, vy;
        longint unsigned dd;
        r = '0;
        if (op == OP_CORRECT) begin
            x8 = 2 * longint'(x) - bias[0];
            y8 = 2 * longint'(y) - bias[1];
            vx = mat[0] * x8 + mat[1] * y8;
            vy = mat[2] * x8 + mat[3] * y8;
            r.ox = 16'(sat16((vx + 4096) >>> 13));
            r.oy = 16'(sat16((vy + 4096) >>> 13));
        end else if (phase_r == PH_TRACE) begin
            if (npts == 0 || (adiff(x, pt_x[npts-1]) > stp[0] &&
                              adiff(y, pt_y[npts-1]) > stp[1])) begin
                if (npts < CAL_SAMPLES) begin
                    pt_x[npts] = x;
                    pt_y[npts] = y;
                    npts++;
                    r.taken = 1'b1;
                end
            end
            dd = adiff(2 * longint'(x), bias[0]) ** 2 + adiff(2 * longint'(y), bias[1]) ** 2;
            if (!min_ok || dd < min_d) begin
                min_d = dd;
                min_ok = 1'b1;
            end
            if (npts >= CAL_SAMPLES) begin
                solve_matrix();
                phase_r = PH_IDLE;
                r.done = 1'b1;
            end
        end else begin
            if (phase_r != PH_RANGE) begin
                lim[0] = x; lim[1] = x; lim[2] = y; lim[3] = y;
                phase_r = PH_RANGE;
            end
            if (x < lim[0]) lim[0] = x;
            if (x > lim[1]) lim[1] = x;
            if (y < lim[2]) lim[2] = y;
            if (y > lim[3]) lim[3] = y;
            if (btn) begin
                bias[0] = lim[0] + lim[1];
                bias[1] = lim[2] + lim[3];
                stp[0] = (lim[1] - lim[0]) / CAL_SAMPLES;
                stp[1] = (lim[3] - lim[2]) / CAL_SAMPLES;
                npts = 0;
                min_d = 0;
                min_ok = 1'b0;
                phase_r = PH_TRACE;
            end
        end
        r.ph = phase_r;
        result_q.push_back(r);
    endtask

    task automatic check_result(logic [39:0] d);
        mag_result_t e, a;
        a.ox = d[15:0];
        a.oy = d[31:16];
        a.ph = d[33:32];
        a.taken = d[34];
        a.done = d[35];
        if (result_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", d);
            return;
        end
        e = result_q.pop_front();
        if (a !== e) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: exp x=%0d y=%0d ph=%0d tk=%b dn=%b",
                          " | got x=%0d y=%0d ph=%0d tk=%b dn=%b"},
                         e.ox, e.oy, e.ph, e.taken, e.done,
                         a.ox, a.oy, a.ph, a.taken, a.done);
        end
    endtask

    initial begin
        errors = 0;
        phase_r = PH_IDLE;
        lim = '{0, 0, 0, 0};
        bias = '{99, -452};
        mat = '{3645, -2442, 3280, 4896};
        stp = '{0, 0};
        npts = 0;
        min_d = 0;
        min_ok = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, int'($signed(s_axis_tdata[15:0])),
                             int'($signed(s_axis_tdata[31:16])), s_axis_tdata[32]);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
    end

endmodule

>>> verif/tb_magnetometer_iron_calibration_unit.sv
`timescale 1ns / 1ps
// Testbench top for magnetometer_iron_calibration_unit: drives corrections and
// full calibration runs with random gaps and stalls. Depends on the DUT and mic_scoreboard.
module tb_magnetometer_iron_calibration_unit;

    localparam logic OP_CORRECT = 1'b0;
    localparam logic OP_CALIB   = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // mag_x, mag_y, button, pad
    logic        s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // out_x, out_y, phase, point_taken, cal_done, pad
    int          errors;
    int          pending;
    int          cal_done_cnt;
    int          stall_left;
    bit          calm;

    magnetometer_iron_calibration_unit dut (.*);

    mic_scoreboard chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            cal_done_cnt <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && m_axis_tdata[35])
                cal_done_cnt <= cal_done_cnt + 1;
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) stall_left <= gap_len();
            end
        end
    end

    // entered at a rising edge, leaves at a rising edge
    task automatic send_item(logic op, logic signed [15:0] x, logic signed [15:0] y, logic btn);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'b0, btn, y, x};
        do @(posedge clk); while (!s_axis_tready);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic calibrate(int cx, int cy, int rad, int nrange, bit extreme);
        int lo_x, hi_x, lo_y, hi_y, x, y, start_cnt, guard;
        lo_x = 32767; hi_x = -32768; lo_y = 32767; hi_y = -32768;
        for (int k = 0; k < nrange; k++) begin
            if (extreme) begin
                x = (k == 0) ? -32768 : 32767;
                y = x;
            end else begin
                x = cx + $urandom_range(0, 2 * rad) - rad;
                y = cy + $urandom_range(0, 2 * rad) - rad;
            end
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
            if (k > 0 && $urandom_range(0, 3) == 0)
                send_item(OP_CORRECT, 16'($urandom), 16'($urandom), 1'b1);
            send_item(OP_CALIB, 16'(x), 16'(y), k == nrange - 1);
        end
        // button during trace is ignored; a correction mid-calibration uses the new bias with the old matrix
        send_item(OP_CALIB, 16'(lo_x), 16'(hi_y), 1'b1);
        send_item(OP_CORRECT, 16'(hi_x), 16'(lo_y), 1'b0);
        start_cnt = cal_done_cnt;
        guard = 0;
        while (cal_done_cnt == start_cnt && guard < 400) begin
            drain();
            guard++;
            // a small margin around the range lets a zero-width range still collect points
            x = $urandom_range(0, hi_x - lo_x + 64) + lo_x - 32;
            y = $urandom_range(0, hi_y - lo_y + 64) + lo_y - 32;
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            if ($urandom_range(0, 14) == 0 && ((lo_x + hi_x) % 2 == 0)
                && ((lo_y + hi_y) % 2 == 0)) begin
                // reading exactly at the bias: zero least distance
                x = (lo_x + hi_x) / 2;
                y = (lo_y + hi_y) / 2;
            end
            if ($urandom_range(0, 9) == 0)
                send_item(OP_CORRECT, 16'($urandom), 16'($urandom), 1'($urandom));
            else
                send_item(OP_CALIB, 16'(x), 16'(y), 1'($urandom));
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = OP_CORRECT;
        s_axis_tdata = '0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corrections at the field extremes and near the default bias with the default calibration
        send_item(OP_CORRECT, 16'sh8000, 16'sh7fff, 1'b0);
        send_item(OP_CORRECT, 16'sh7fff, 16'sh8000, 1'b0);
        send_item(OP_CORRECT, 16'sh7fff, 16'sh7fff, 1'b1);
        send_item(OP_CORRECT, 16'sh8000, 16'sh8000, 1'b0);
        send_item(OP_CORRECT, 16'sd0, 16'sd0, 1'b0);
        send_item(OP_CORRECT, 16'sd50, -16'sd226, 1'b0);

        calibrate(0, 0, 0, 2, 1'b1);
        for (int k = 0; k < 4; k++)
            send_item(OP_CORRECT, 16'($urandom), 16'($urandom), 1'b0);
        calibrate(100, -200, 0, 1, 1'b0);    // button on the very first item

        for (int run = 0; run < 4; run++) begin
            calm = (run == 2);
            for (int k = 0; k < 15; k++)
                send_item(OP_CORRECT, 16'($urandom), 16'($urandom), 1'($urandom));
            if (run % 3 == 0)
                calibrate($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                          $urandom_range(10, 40), $urandom_range(1, 6), 1'b0);
            else
                calibrate($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000,
                          $urandom_range(500, 12000), $urandom_range(2, 8), 1'b0);
        end
        calm = 1'b0;
        for (int k = 0; k < 40; k++)
            send_item(OP_CORRECT, 16'($urandom), 16'($urandom), 1'($urandom));

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
